// File: hw/rtl/memory_balloon_rebalance_policy_defines.svh
// ----------------------------------------------------------------------------
// Balloon rebalance policy assertion macros
// Concurrent assertion shorthands clocked on clock, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MEMORY_BALLOON_REBALANCE_POLICY_DEFINES_SVH
`define MEMORY_BALLOON_REBALANCE_POLICY_DEFINES_SVH

// same-cycle implication
`define MBRP_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MBRP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/mbrp_pkg.sv
// ----------------------------------------------------------------------------
// Balloon rebalance policy package
// Shared constants, command and status types and saturating arithmetic.
// ----------------------------------------------------------------------------
package mbrp_pkg;

   localparam int MAX_GUESTS = 8;
   localparam int IDX_W      = (MAX_GUESTS > 1) ? $clog2(MAX_GUESTS) : 1;
   localparam int CNT_W      = $clog2(MAX_GUESTS + 1);
   localparam int DATA_W     = 32;
   localparam int OUT_IDX_W  = 5;
   localparam int CSR_IDX_W  = 4;

   localparam logic [DATA_W-1:0] LOADED_THR_RESET = DATA_W'(150 * 1024);
   localparam logic [DATA_W-1:0] FREE_THR_RESET   = DATA_W'(200 * 1024);

   localparam logic [CSR_IDX_W-1:0] CSR_LOADED_THR = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FREE_THR   = CSR_IDX_W'(1);

   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_END    = 1'b1;

   typedef enum logic [1:0] {
      RD_SEL_MOST  = 2'd0,
      RD_SEL_LEAST = 2'd1,
      RD_SEL_SWEEP = 2'd2
   } rd_sel_type;

   typedef struct packed {
      logic       store_report;
      logic       latch_host;
      rd_sel_type rd_sel;
      logic       gen_most;
      logic       gen_least;
      logic       gen_sweep;
      logic       sweep_inc;
      logic       flush;
   } ctrl_cmd_type;

   typedef struct packed {
      logic sweep_go;
      logic sweep_last;
   } dp_status_type;

   function automatic logic [DATA_W-1:0] sat_sub(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] r;
      r = (a > b) ? (a - b) : '0;
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
      logic [DATA_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[DATA_W] ? '1 : s[DATA_W-1:0];
   endfunction

endpackage

// File: hw/rtl/mbrp_datapath.sv
// ----------------------------------------------------------------------------
// Balloon rebalance policy datapath
// Guest report store, extreme tracking, threshold registers and command output.
// ----------------------------------------------------------------------------
module mbrp_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  mbrp_pkg::ctrl_cmd_type              cmd,
   output mbrp_pkg::dp_status_type             status,
   input  logic [mbrp_pkg::DATA_W-1:0]         req_unused_kib,
   input  logic [mbrp_pkg::DATA_W-1:0]         req_available_kib,
   input  logic [mbrp_pkg::DATA_W-1:0]         req_host_free_kib,
   input  logic                                csr_write,
   input  logic [mbrp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mbrp_pkg::DATA_W-1:0]         csr_wdata,
   output logic                                rsp_strobe,
   output logic [mbrp_pkg::OUT_IDX_W-1:0]      rsp_guest_index,
   output logic [mbrp_pkg::DATA_W-1:0]         rsp_new_size_kib,
   output logic                                rsp_last
);

   logic [mbrp_pkg::DATA_W-1:0] guest_unused_ff    [mbrp_pkg::MAX_GUESTS];
   logic [mbrp_pkg::DATA_W-1:0] guest_available_ff [mbrp_pkg::MAX_GUESTS];
   logic [mbrp_pkg::DATA_W-1:0] rd_unused_ff, rd_available_ff;

   logic [mbrp_pkg::DATA_W-1:0] loaded_thr_ff, loaded_thr_in;
   logic [mbrp_pkg::DATA_W-1:0] free_thr_ff, free_thr_in;
   logic [mbrp_pkg::DATA_W-1:0] host_ff, host_in;

   logic [mbrp_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [mbrp_pkg::IDX_W-1:0]  most_idx_ff, most_idx_in;
   logic [mbrp_pkg::IDX_W-1:0]  least_idx_ff, least_idx_in;
   logic [mbrp_pkg::DATA_W-1:0] most_val_ff, most_val_in;
   logic [mbrp_pkg::DATA_W-1:0] least_val_ff, least_val_in;
   logic [mbrp_pkg::IDX_W-1:0]  sweep_idx_ff, sweep_idx_in;

   logic                        pend_valid_ff, pend_valid_in;
   logic [mbrp_pkg::IDX_W-1:0]  pend_idx_ff, pend_idx_in;
   logic [mbrp_pkg::DATA_W-1:0] pend_size_ff, pend_size_in;

   logic                        out_strobe_ff, out_strobe_in;
   logic [mbrp_pkg::IDX_W-1:0]  out_idx_ff, out_idx_in;
   logic [mbrp_pkg::DATA_W-1:0] out_size_ff, out_size_in;
   logic                        out_last_ff, out_last_in;

   logic                        wr_en;
   logic [mbrp_pkg::IDX_W-1:0]  wr_addr;
   logic [mbrp_pkg::IDX_W-1:0]  rd_addr;
   logic                        count_nz;
   logic                        donor;
   logic                        starved;
   logic                        gen_hit;
   logic [mbrp_pkg::IDX_W-1:0]  gen_idx;
   logic [mbrp_pkg::DATA_W-1:0] gen_size;

   assign wr_addr  = count_ff[mbrp_pkg::IDX_W-1:0];
   assign wr_en    = cmd.store_report &&
                     (count_ff < mbrp_pkg::CNT_W'(mbrp_pkg::MAX_GUESTS));
   assign count_nz = (count_ff != '0);
   assign donor    = count_nz && (most_val_ff >= free_thr_ff);
   assign starved  = count_nz && (least_val_ff <= loaded_thr_ff);

   assign status.sweep_go   = count_nz && (host_ff <= loaded_thr_ff);
   assign status.sweep_last = (mbrp_pkg::CNT_W'(sweep_idx_ff) + mbrp_pkg::CNT_W'(1))
                              >= count_ff;

   always_comb begin
      unique case (cmd.rd_sel)
         mbrp_pkg::RD_SEL_MOST:  rd_addr = most_idx_ff;
         mbrp_pkg::RD_SEL_LEAST: rd_addr = least_idx_ff;
         mbrp_pkg::RD_SEL_SWEEP: rd_addr = sweep_idx_ff;
         default:                rd_addr = sweep_idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         guest_unused_ff[wr_addr]    <= req_unused_kib;
         guest_available_ff[wr_addr] <= req_available_kib;
      end
      rd_unused_ff    <= guest_unused_ff[rd_addr];
      rd_available_ff <= guest_available_ff[rd_addr];
   end

   always_comb begin
      loaded_thr_in = loaded_thr_ff;
      free_thr_in   = free_thr_ff;
      if (csr_write && (csr_index == mbrp_pkg::CSR_LOADED_THR)) begin
         loaded_thr_in = csr_wdata;
      end
      if (csr_write && (csr_index == mbrp_pkg::CSR_FREE_THR)) begin
         free_thr_in = csr_wdata;
      end
   end

   always_comb begin
      host_in      = cmd.latch_host ? req_host_free_kib : host_ff;
      count_in     = count_ff;
      most_idx_in  = most_idx_ff;
      least_idx_in = least_idx_ff;
      most_val_in  = most_val_ff;
      least_val_in = least_val_ff;
      sweep_idx_in = sweep_idx_ff;
      if (cmd.latch_host) begin
         sweep_idx_in = '0;
      end else if (cmd.sweep_inc) begin
         sweep_idx_in = sweep_idx_ff + mbrp_pkg::IDX_W'(1);
      end
      if (wr_en) begin
         count_in = count_ff + mbrp_pkg::CNT_W'(1);
         if (!count_nz) begin
            most_idx_in  = '0;
            least_idx_in = '0;
            most_val_in  = req_unused_kib;
            least_val_in = req_unused_kib;
         end else begin
            if (req_unused_kib > most_val_ff) begin
               most_idx_in = wr_addr;
               most_val_in = req_unused_kib;
            end
            if (req_unused_kib < least_val_ff) begin
               least_idx_in = wr_addr;
               least_val_in = req_unused_kib;
            end
         end
      end else if (cmd.flush) begin
         count_in     = '0;
         most_idx_in  = '0;
         least_idx_in = '0;
         most_val_in  = '0;
         least_val_in = '0;
      end
   end

   always_comb begin
      gen_hit  = 1'b0;
      gen_idx  = sweep_idx_ff;
      gen_size = mbrp_pkg::sat_sub(rd_available_ff, loaded_thr_ff);
      priority if (cmd.gen_most) begin
         gen_hit = donor;
         gen_idx = most_idx_ff;
      end else if (cmd.gen_least) begin
         gen_hit  = starved;
         gen_idx  = least_idx_ff;
         gen_size = mbrp_pkg::sat_add(rd_available_ff,
                                      donor ? loaded_thr_ff : free_thr_ff);
      end else if (cmd.gen_sweep) begin
         gen_hit = (rd_unused_ff >= free_thr_ff);
      end else begin
         gen_hit = 1'b0;
      end
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      pend_size_in  = pend_size_ff;
      out_strobe_in = 1'b0;
      out_idx_in    = pend_idx_ff;
      out_size_in   = pend_size_ff;
      out_last_in   = 1'b0;
      if (gen_hit) begin
         out_strobe_in = pend_valid_ff;
         pend_valid_in = 1'b1;
         pend_idx_in   = gen_idx;
         pend_size_in  = gen_size;
      end else if (cmd.flush) begin
         out_strobe_in = pend_valid_ff;
         out_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_thr_ff <= mbrp_pkg::LOADED_THR_RESET;
         free_thr_ff   <= mbrp_pkg::FREE_THR_RESET;
         count_ff      <= '0;
         most_idx_ff   <= '0;
         least_idx_ff  <= '0;
         most_val_ff   <= '0;
         least_val_ff  <= '0;
         sweep_idx_ff  <= '0;
         pend_valid_ff <= 1'b0;
         out_strobe_ff <= 1'b0;
      end else begin
         loaded_thr_ff <= loaded_thr_in;
         free_thr_ff   <= free_thr_in;
         count_ff      <= count_in;
         most_idx_ff   <= most_idx_in;
         least_idx_ff  <= least_idx_in;
         most_val_ff   <= most_val_in;
         least_val_ff  <= least_val_in;
         sweep_idx_ff  <= sweep_idx_in;
         pend_valid_ff <= pend_valid_in;
         out_strobe_ff <= out_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      host_ff      <= host_in;
      pend_idx_ff  <= pend_idx_in;
      pend_size_ff <= pend_size_in;
      out_idx_ff   <= out_idx_in;
      out_size_ff  <= out_size_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_strobe       = out_strobe_ff;
   assign rsp_guest_index  = mbrp_pkg::OUT_IDX_W'(out_idx_ff);
   assign rsp_new_size_kib = out_size_ff;
   assign rsp_last         = out_last_ff;

endmodule

// File: hw/rtl/mbrp_ctrl.sv
// ----------------------------------------------------------------------------
// Balloon rebalance policy controller
// Sequences the end-of-round decisions and the host-low sweep.
// ----------------------------------------------------------------------------
module mbrp_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     req_kind,
   output logic                     busy,
   output mbrp_pkg::ctrl_cmd_type   cmd,
   input  mbrp_pkg::dp_status_type  status
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_RD_MOST  = 8'b0000_0010,
      ST_EX_MOST  = 8'b0000_0100,
      ST_RD_LEAST = 8'b0000_1000,
      ST_EX_LEAST = 8'b0001_0000,
      ST_SW_RD    = 8'b0010_0000,
      ST_SW_EX    = 8'b0100_0000,
      ST_FLUSH    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      state_in         = state_ff;
      cmd              = '0;
      cmd.rd_sel       = mbrp_pkg::RD_SEL_SWEEP;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_kind == mbrp_pkg::KIND_REPORT)) begin
               cmd.store_report = 1'b1;
            end
            if (accept && (req_kind == mbrp_pkg::KIND_END)) begin
               cmd.latch_host = 1'b1;
               state_in       = ST_RD_MOST;
            end
         end
         ST_RD_MOST: begin
            cmd.rd_sel = mbrp_pkg::RD_SEL_MOST;
            state_in   = ST_EX_MOST;
         end
         ST_EX_MOST: begin
            cmd.gen_most = 1'b1;
            state_in     = ST_RD_LEAST;
         end
         ST_RD_LEAST: begin
            cmd.rd_sel = mbrp_pkg::RD_SEL_LEAST;
            state_in   = ST_EX_LEAST;
         end
         ST_EX_LEAST: begin
            cmd.gen_least = 1'b1;
            state_in      = status.sweep_go ? ST_SW_RD : ST_FLUSH;
         end
         ST_SW_RD: begin
            state_in = ST_SW_EX;
         end
         ST_SW_EX: begin
            cmd.gen_sweep = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_FLUSH;
            end else begin
               cmd.sweep_inc = 1'b1;
               state_in      = ST_SW_RD;
            end
         end
         ST_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/memory_balloon_rebalance_policy.sv
// Guest report: taken whenever busy is low; no result.
// End of round: most and least unused guests, then all stored guests when the host is low on memory.
// Each result leaves in the cycle after the next is decided, the last in the cycle
// after the round ends, in the first idle cycle; the receiver cannot stall them.
// Sweep length is set by one registered read of the report store per guest.
// Synchronous reset clears the round state and loads the threshold reset values.
// ----------------------------------------------------------------------------
// Balloon rebalance policy top level
// Collects guest memory reports and issues set-size commands at round end.
// ----------------------------------------------------------------------------
`include "memory_balloon_rebalance_policy_defines.svh"

module memory_balloon_rebalance_policy (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_kind,
   input  logic [mbrp_pkg::DATA_W-1:0]         req_unused_kib,
   input  logic [mbrp_pkg::DATA_W-1:0]         req_available_kib,
   input  logic [mbrp_pkg::DATA_W-1:0]         req_host_free_kib,
   output logic                                rsp_strobe,
   output logic [mbrp_pkg::OUT_IDX_W-1:0]      rsp_guest_index,
   output logic [mbrp_pkg::DATA_W-1:0]         rsp_new_size_kib,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mbrp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mbrp_pkg::DATA_W-1:0]         csr_wdata
);

   mbrp_pkg::ctrl_cmd_type  cmd;
   mbrp_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   mbrp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .busy     (busy),
      .cmd      (cmd),
      .status   (status)
   );

   mbrp_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_unused_kib    (req_unused_kib),
      .req_available_kib (req_available_kib),
      .req_host_free_kib (req_host_free_kib),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_strobe        (rsp_strobe),
      .rsp_guest_index   (rsp_guest_index),
      .rsp_new_size_kib  (rsp_new_size_kib),
      .rsp_last          (rsp_last)
   );

   `MBRP_ASSERT_IMPLIES(a_rsp_in_round, rsp_strobe, $past(busy), "result outside a round")
   `MBRP_ASSERT_NEXT(a_last_ends_burst, rsp_strobe && rsp_last, !rsp_strobe, "result after last")
   `MBRP_ASSERT_NEXT(a_end_goes_busy, start && !busy && req_kind, busy, "round end not taken")
   `MBRP_ASSERT_NEXT(a_report_stays_idle, start && !busy && !req_kind, !busy, "report held busy")

endmodule
